/* hdl/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// Thrust curve statistics package
// Shared widths, payload structs, configuration register map and the run
// summary that travels from the sample front end to the result back end.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_SAMPLES = 1048576;
  localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int PEAK_W      = SAMPLE_BITS - 1;
  localparam int TIME_W      = 40;
  localparam int ACC_W       = 64;
  localparam int SUM_W       = 48;
  localparam int ISP_W       = 56;
  localparam int PERIOD_W    = 30;
  localparam int MASS_W      = 32;
  localparam int RDIV_W      = 16;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;

  // Standard gravity times 512000: 1/512 N ns per mg becomes seconds.
  localparam int ISP_CONST_W = 23;
  localparam logic [ISP_CONST_W-1:0] ISP_DIVISOR = 23'd5021005;
  localparam int ISP_FRAC    = 8;

  // Shared serial divider geometry.
  localparam int DENOM_W = MASS_W + ISP_CONST_W;
  localparam int DVD_W   = ACC_W + ISP_FRAC;
  localparam int STEP_W  = $clog2(DVD_W + 1);

  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_FIXED_RATE = 2'd0,
    CFG_SAMPLE_PERIOD  = 2'd1,
    CFG_PROP_MASS      = 2'd2,
    CFG_RATIO_DIVISOR  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                use_fixed_rate;
    logic [PERIOD_W-1:0] sample_period_ns;
    logic [MASS_W-1:0]   propellant_mass_mg;
    logic [RDIV_W-1:0]   ratio_divisor;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] thrust_sample;
    logic [TIME_W-1:0]             sample_time_ns;
    logic                          last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [ACC_W-1:0]       total_impulse;
    logic signed [ISP_W-1:0]       specific_impulse_q8;
    logic signed [SAMPLE_BITS-1:0] mean_thrust;
    logic [PEAK_W-1:0]             peak_thrust;
    logic [PEAK_W-1:0]             peak_ratio;
  } result_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] impulse;
    logic signed [SUM_W-1:0] thrust_sum;
    logic [COUNT_W-1:0]      sample_count;
    logic [PEAK_W-1:0]       peak;
  } run_summary_t;

endpackage

/* hdl/tcs_front.sv */
// ----------------------------------------------------------------------------
// Thrust curve statistics front end
// Accepts samples, forms the trapezoid term with a two-part multiply and keeps
// the saturating impulse, sum, count and peak of the current run.
// ----------------------------------------------------------------------------
module tcs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  tcs_pkg::cfg_t         cfg,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  tcs_pkg::sample_t      sample,
  output logic                  push,
  output tcs_pkg::run_summary_t summary,
  input  logic                  full
);

  localparam int SB    = tcs_pkg::SAMPLE_BITS;
  localparam int SMAG  = SB + 1;
  localparam int DLO   = tcs_pkg::TIME_W / 2;
  localparam int DHI   = tcs_pkg::TIME_W - DLO;
  localparam int PLO_W = SMAG + DLO;
  localparam int PHI_W = SMAG + DHI;
  localparam int PROD_W = PHI_W + DLO + 1;
  localparam int AW    = tcs_pkg::ACC_W;
  localparam int SW    = tcs_pkg::SUM_W;

  localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'({1'b0, {(AW-1){1'b1}}});
  localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'({1'b1, {(AW-1){1'b0}}});
  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_SAT,
    S_FINISH
  } state_t;

  state_t state;

  logic                              have_prev;
  logic signed [SB-1:0]              prev_thrust;
  logic [tcs_pkg::TIME_W-1:0]        prev_time;
  logic signed [AW-1:0]              acc;
  logic signed [SW-1:0]              sum;
  logic [tcs_pkg::COUNT_W-1:0]       count;
  logic [tcs_pkg::PEAK_W-1:0]        peak;
  logic                              last;
  logic [SMAG-1:0]                   mag_s;
  logic [tcs_pkg::TIME_W-1:0]        mag_dt;
  logic                              neg;
  logic [PLO_W-1:0]                  p_lo;
  logic [PHI_W-1:0]                  p_hi;
  logic signed [AW-1:0]              term;

  logic                              accept;
  logic signed [SMAG-1:0]            s_wide;
  logic [tcs_pkg::TIME_W:0]          dt_diff;
  logic [tcs_pkg::TIME_W:0]          dt_abs;
  logic                              dt_neg;
  logic [tcs_pkg::TIME_W-1:0]        dt_mag;
  logic [SMAG-1:0]                   s_mag;
  logic signed [SW:0]                sum_ext;
  logic signed [SW-1:0]              sum_sat;
  logic [PROD_W-1:0]                 prod;
  logic signed [AW:0]                acc_ext;
  logic signed [AW-1:0]              acc_sat;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;

  always_comb begin
    s_wide  = {sample.thrust_sample[SB-1], sample.thrust_sample}
            + {prev_thrust[SB-1], prev_thrust};
    s_mag   = s_wide[SMAG-1] ? SMAG'(-s_wide) : SMAG'(s_wide);
    dt_diff = {1'b0, sample.sample_time_ns} - {1'b0, prev_time};
    dt_abs  = dt_diff[tcs_pkg::TIME_W] ? (~dt_diff + 1'b1) : dt_diff;
    if (cfg.use_fixed_rate) begin
      dt_neg = 1'b0;
      dt_mag = tcs_pkg::TIME_W'(cfg.sample_period_ns);
    end else begin
      dt_neg = dt_diff[tcs_pkg::TIME_W];
      dt_mag = dt_abs[tcs_pkg::TIME_W-1:0];
    end
    sum_ext = {sum[SW-1], sum} + (SW+1)'(sample.thrust_sample);
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      sum_sat = sum_ext[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SW-1:0];
    end
    prod    = {1'b0, p_hi, {DLO{1'b0}}} + PROD_W'(p_lo);
    acc_ext = {acc[AW-1], acc} + {term[AW-1], term};
    if (acc_ext[AW] != acc_ext[AW-1]) begin
      acc_sat = acc_ext[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_ext[AW-1:0];
    end
  end

  assign push    = (state == S_FINISH) && last && !full;
  assign summary = '{impulse: acc_sat, thrust_sum: sum, sample_count: count, peak: peak};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      have_prev   <= 1'b0;
      prev_thrust <= '0;
      prev_time   <= '0;
      acc         <= '0;
      sum         <= '0;
      count       <= '0;
      peak        <= '0;
      last        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last        <= sample.last_sample;
            mag_s       <= s_mag;
            mag_dt      <= dt_mag;
            neg         <= s_wide[SMAG-1] ^ dt_neg;
            term        <= '0;
            have_prev   <= 1'b1;
            prev_thrust <= sample.thrust_sample;
            prev_time   <= sample.sample_time_ns;
            if (count < tcs_pkg::COUNT_W'(tcs_pkg::MAX_SAMPLES)) begin
              sum   <= sum_sat;
              count <= count + 1'b1;
            end
            if (sample.thrust_sample > $signed({1'b0, peak})) begin
              peak <= sample.thrust_sample[tcs_pkg::PEAK_W-1:0];
            end
            // The first sample of a run has no trapezoid term.
            state <= have_prev ? S_MUL_LO : S_FINISH;
          end
        end
        S_MUL_LO: begin
          p_lo  <= mag_s * mag_dt[DLO-1:0];
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          p_hi  <= mag_s * mag_dt[tcs_pkg::TIME_W-1:DLO];
          state <= S_SAT;
        end
        S_SAT: begin
          if (neg) begin
            term <= (prod > NEG_LIMIT) ? ACC_MIN : AW'(-prod);
          end else begin
            term <= (prod > POS_LIMIT) ? ACC_MAX : AW'(prod);
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!(last && full)) begin
            state <= S_IDLE;
            if (last) begin
              have_prev   <= 1'b0;
              prev_thrust <= '0;
              prev_time   <= '0;
              acc         <= '0;
              sum         <= '0;
              count       <= '0;
              peak        <= '0;
            end else begin
              acc <= acc_sat;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tcs_queue.sv */
// ----------------------------------------------------------------------------
// Thrust curve statistics run queue
// Two-entry queue of finished run summaries between front and back end.
// ----------------------------------------------------------------------------
module tcs_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tcs_pkg::run_summary_t push_data,
  output logic                  full,
  input  logic                  pop,
  output tcs_pkg::run_summary_t pop_data,
  output logic                  avail
);

  tcs_pkg::run_summary_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;

  assign full     = (level == 2'd2);
  assign avail    = (level != 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

/* hdl/tcs_divider.sv */
// ----------------------------------------------------------------------------
// Thrust curve statistics serial divider
// Restoring divider that retires one quotient bit per cycle. The dividend is
// left aligned, and the step count says how many of its top bits are used.
// ----------------------------------------------------------------------------
module tcs_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tcs_pkg::DVD_W-1:0]    dividend,
  input  logic [tcs_pkg::DENOM_W-1:0]  divisor,
  input  logic [tcs_pkg::STEP_W-1:0]   steps,
  output logic                         busy,
  output logic [tcs_pkg::DVD_W-1:0]    quotient
);

  localparam int DW = tcs_pkg::DVD_W;
  localparam int NW = tcs_pkg::DENOM_W;

  logic [DW-1:0]                dvd;
  logic [NW-1:0]                dvs;
  logic [NW-1:0]                rem;
  logic [tcs_pkg::STEP_W-1:0]   count;

  logic [NW:0]                  shifted;
  logic [NW+1:0]                diff;

  assign busy = (count != '0);

  always_comb begin
    shifted = {rem, dvd[DW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DW-2:0], 1'b0};
      rem      <= diff[NW+1] ? shifted[NW-1:0] : diff[NW-1:0];
      quotient <= {quotient[DW-2:0], ~diff[NW+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= steps;
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

endmodule

/* hdl/tcs_back.sv */
// ----------------------------------------------------------------------------
// Thrust curve statistics back end
// Takes a finished run from the queue, runs the specific impulse, mean and
// peak ratio divisions on the shared divider and holds the result beat.
// ----------------------------------------------------------------------------
module tcs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  tcs_pkg::cfg_t                cfg,
  input  logic                         avail,
  output logic                         pop,
  input  tcs_pkg::run_summary_t        job_in,
  output logic                         div_start,
  output logic [tcs_pkg::DVD_W-1:0]    div_dividend,
  output logic [tcs_pkg::DENOM_W-1:0]  div_divisor,
  output logic [tcs_pkg::STEP_W-1:0]   div_steps,
  input  logic                         div_busy,
  input  logic [tcs_pkg::DVD_W-1:0]    div_quotient,
  output logic                         result_valid,
  input  logic                         result_ready,
  output tcs_pkg::result_t             result
);

  localparam int DW  = tcs_pkg::DVD_W;
  localparam int NW  = tcs_pkg::DENOM_W;
  localparam int AW  = tcs_pkg::ACC_W;
  localparam int SW  = tcs_pkg::SUM_W;
  localparam int IW  = tcs_pkg::ISP_W;
  localparam int SB  = tcs_pkg::SAMPLE_BITS;
  localparam int PW  = tcs_pkg::PEAK_W;

  localparam logic [DW-1:0] ISP_POS_LIM = DW'({1'b0, {(IW-1){1'b1}}});
  localparam logic [DW-1:0] ISP_NEG_LIM = DW'({1'b1, {(IW-1){1'b0}}});
  localparam logic [SW-1:0] MEAN_POS_LIM = SW'({1'b0, {(SB-1){1'b1}}});
  localparam logic [SW-1:0] MEAN_NEG_LIM = SW'({1'b1, {(SB-1){1'b0}}});

  typedef enum logic [3:0] {
    S_IDLE,
    S_DENOM,
    S_ISP_GO,
    S_ISP_WAIT,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_RATIO_GO,
    S_RATIO_WAIT,
    S_RESULT
  } state_t;

  state_t state;

  tcs_pkg::run_summary_t job;
  logic [NW-1:0]         denom;
  logic [DW-1:0]         isp_q;
  logic [SW-1:0]         mean_q;
  logic [PW-1:0]         ratio_q;

  logic [AW-1:0]         acc_mag;
  logic [SW-1:0]         sum_mag;
  logic [IW:0]           isp_neg_mag;
  logic [SW-1:0]         mean_mag;
  tcs_pkg::result_t      next_result;
  logic                  load;

  assign pop  = (state == S_IDLE) && avail;
  assign load = (state == S_RESULT) && (!result_valid || result_ready);

  always_comb begin
    acc_mag = job.impulse[AW-1] ? AW'(-job.impulse) : AW'(job.impulse);
    sum_mag = job.thrust_sum[SW-1] ? SW'(-job.thrust_sum) : SW'(job.thrust_sum);

    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    unique case (state)
      S_ISP_GO: begin
        div_start    = 1'b1;
        div_dividend = {acc_mag, {tcs_pkg::ISP_FRAC{1'b0}}};
        div_divisor  = denom;
        div_steps    = tcs_pkg::STEP_W'(DW);
      end
      S_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = {sum_mag, {(DW-SW){1'b0}}};
        div_divisor  = NW'(job.sample_count);
        div_steps    = tcs_pkg::STEP_W'(SW);
      end
      S_RATIO_GO: begin
        div_start    = 1'b1;
        div_dividend = {job.peak, {(DW-PW){1'b0}}};
        div_divisor  = NW'(cfg.ratio_divisor);
        div_steps    = tcs_pkg::STEP_W'(PW);
      end
      default: ;
    endcase
  end

  always_comb begin
    next_result.total_impulse = job.impulse;

    // Zero impulse gives zero; zero mass saturates toward the impulse's sign.
    isp_neg_mag = (isp_q > ISP_NEG_LIM) ? (IW+1)'(ISP_NEG_LIM) : isp_q[IW:0];
    if (job.impulse == '0) begin
      next_result.specific_impulse_q8 = '0;
    end else if (denom == '0) begin
      next_result.specific_impulse_q8 = job.impulse[AW-1] ? IW'(ISP_NEG_LIM)
                                                           : IW'(ISP_POS_LIM);
    end else if (job.impulse[AW-1]) begin
      next_result.specific_impulse_q8 = IW'(-isp_neg_mag);
    end else begin
      next_result.specific_impulse_q8 = (isp_q > ISP_POS_LIM) ? IW'(ISP_POS_LIM)
                                                              : isp_q[IW-1:0];
    end

    if (job.thrust_sum[SW-1]) begin
      mean_mag = (mean_q > MEAN_NEG_LIM) ? MEAN_NEG_LIM : mean_q;
      next_result.mean_thrust = SB'(-mean_mag);
    end else begin
      mean_mag = (mean_q > MEAN_POS_LIM) ? MEAN_POS_LIM : mean_q;
      next_result.mean_thrust = mean_mag[SB-1:0];
    end

    next_result.peak_thrust = job.peak;
    next_result.peak_ratio  = (cfg.ratio_divisor == '0) ? tcs_pkg::PEAK_MAX : ratio_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result       <= next_result;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            job   <= job_in;
            state <= S_DENOM;
          end
        end
        S_DENOM: begin
          denom <= cfg.propellant_mass_mg * tcs_pkg::ISP_DIVISOR;
          state <= S_ISP_GO;
        end
        S_ISP_GO:  state <= S_ISP_WAIT;
        S_ISP_WAIT: begin
          if (!div_busy) begin
            isp_q <= div_quotient;
            state <= S_MEAN_GO;
          end
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (!div_busy) begin
            mean_q <= div_quotient[SW-1:0];
            state  <= S_RATIO_GO;
          end
        end
        S_RATIO_GO: state <= S_RATIO_WAIT;
        S_RATIO_WAIT: begin
          if (!div_busy) begin
            ratio_q <= div_quotient[PW-1:0];
            state   <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/thrust_curve_statistics.sv */
// ----------------------------------------------------------------------------
// Thrust curve statistics
// Trapezoidal impulse integration with mean, peak and specific impulse.
// ----------------------------------------------------------------------------
// Samples arrive on the sample channel (valid/ready, one beat per sample).
// The front end works on one sample at a time: a 25 x 40 bit multiply split
// into two 25 x 20 bit halves forms the trapezoid term, which is saturated
// and added to the impulse accumulator; the first sample of a run has none.
// A beat with last_sample set closes the run. Its summary goes into a
// two-entry queue; the front end is ready for the next run once it has room.
// The back end turns each summary into one result beat through a shared
// one-bit-per-cycle divider: 72 steps for specific impulse, 48 for the mean
// and 23 for the peak ratio, one after another.
// The result register holds a beat until the receiver takes it; the back end
// stalls in front of it, and the queue then fills and stalls the front end.
// The user must write configuration (cfg_write, cfg_index, cfg_data) only
// while the block is idle; the block does not check. Synchronous reset
// restores register defaults and clears run state, queue and result register.
// ----------------------------------------------------------------------------
module thrust_curve_statistics (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcs_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  tcs_pkg::sample_t                sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output tcs_pkg::result_t                result
);

  tcs_pkg::cfg_t          cfg;
  logic                   push;
  logic                   full;
  logic                   pop;
  logic                   avail;
  tcs_pkg::run_summary_t  push_data;
  tcs_pkg::run_summary_t  pop_data;
  logic                   div_start;
  logic [tcs_pkg::DVD_W-1:0]   div_dividend;
  logic [tcs_pkg::DENOM_W-1:0] div_divisor;
  logic [tcs_pkg::STEP_W-1:0]  div_steps;
  logic                   div_busy;
  logic [tcs_pkg::DVD_W-1:0]   div_quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_fixed_rate     <= 1'b1;
      cfg.sample_period_ns   <= tcs_pkg::PERIOD_W'(1000);
      cfg.propellant_mass_mg <= tcs_pkg::MASS_W'(1000);
      cfg.ratio_divisor      <= tcs_pkg::RDIV_W'(1);
    end else if (cfg_write) begin
      unique case (tcs_pkg::cfg_index_t'(cfg_index))
        tcs_pkg::CFG_USE_FIXED_RATE: cfg.use_fixed_rate     <= cfg_data[0];
        tcs_pkg::CFG_SAMPLE_PERIOD:  cfg.sample_period_ns   <= cfg_data[tcs_pkg::PERIOD_W-1:0];
        tcs_pkg::CFG_PROP_MASS:      cfg.propellant_mass_mg <= cfg_data[tcs_pkg::MASS_W-1:0];
        tcs_pkg::CFG_RATIO_DIVISOR:  cfg.ratio_divisor      <= cfg_data[tcs_pkg::RDIV_W-1:0];
        default: ;
      endcase
    end
  end

  tcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .push         (push),
    .summary      (push_data),
    .full         (full)
  );

  tcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .avail     (avail)
  );

  tcs_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  tcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .avail        (avail),
    .pop          (pop),
    .job_in       (pop_data),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_steps    (div_steps),
    .div_busy     (div_busy),
    .div_quotient (div_quotient),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // The front end never writes a run summary into a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("run summary pushed into a full queue");

  // A sample beat keeps the front end busy for at least the next cycle.
  a_one_sample_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("front end took a sample while still working");

  // The divider is never restarted while it is still working.
  a_divider_not_restarted: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // A zero impulse always reports zero specific impulse.
  a_zero_impulse_isp: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.total_impulse == '0) |-> result.specific_impulse_q8 == '0)
    else $error("nonzero specific impulse for zero impulse");

  // With a nonzero divisor the ratio cannot exceed the peak.
  a_ratio_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && cfg.ratio_divisor != '0) |-> result.peak_ratio <= result.peak_thrust)
    else $error("peak ratio above peak thrust");

endmodule

/* bench/thrust_curve_statistics_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Thrust curve statistics testbench
// Drives runs of thrust samples through the block and predicts every result
// beat from its own model of the trapezoid impulse, specific impulse, mean and
// peak arithmetic. Directed runs hit the saturation limits and the zero-mass,
// zero-divisor and zero-period corners; random runs follow under several
// settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module thrust_curve_statistics_test;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 336;

  localparam logic [tcs_pkg::TIME_W-1:0] TIME_MAX = {tcs_pkg::TIME_W{1'b1}};
  localparam logic signed [23:0] THRUST_MAX    = 24'sh7FFFFF;
  localparam logic signed [23:0] THRUST_MIN    = 24'sh800000;
  localparam longint             I64_HI        = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint             I64_LO        = 64'sh8000_0000_0000_0000;
  localparam longint             SUM_HI        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint             SUM_LO        = -SUM_HI - 1;
  localparam logic [55:0]        ISP_POS_LIMIT = 56'h7F_FFFF_FFFF_FFFF;
  localparam logic [55:0]        ISP_NEG_LIMIT = 56'h80_0000_0000_0000;
  // Standard gravity scaled so that 1/512 N ns per mg comes out in seconds.
  localparam logic [22:0]        GRAVITY_SCALE = 23'd5021005;

  class run_scoreboard;
    bit                 fixed_rate;
    logic [29:0]        period;
    logic [31:0]        mass;
    logic [15:0]        rdiv;
    bit                 have_prev;
    logic signed [23:0] prev_thrust;
    logic [39:0]        prev_time;
    longint             impulse_acc;
    longint             thrust_sum;
    logic [22:0]        peak;
    int                 count;
    tcs_pkg::result_t   pending_runs[$];
    int                 mismatches;

    function new();
      fixed_rate = 1'b1;
      period     = 30'd1000;
      mass       = 32'd1000;
      rdiv       = 16'd1;
      mismatches = 0;
      clear_run();
    endfunction

    function void clear_run();
      have_prev   = 1'b0;
      prev_thrust = '0;
      prev_time   = '0;
      impulse_acc = 0;
      thrust_sum  = 0;
      peak        = '0;
      count       = 0;
    endfunction

    function void write_reg(tcs_pkg::cfg_index_t idx, logic [31:0] d);
      case (idx)
        tcs_pkg::CFG_USE_FIXED_RATE: fixed_rate = d[0];
        tcs_pkg::CFG_SAMPLE_PERIOD:  period = d[29:0];
        tcs_pkg::CFG_PROP_MASS:      mass = d;
        tcs_pkg::CFG_RATIO_DIVISOR:  rdiv = d[15:0];
        default: ;
      endcase
    endfunction

    function longint sat64(logic signed [127:0] v);
      if (v > I64_HI) return I64_HI;
      if (v < I64_LO) return I64_LO;
      return v[63:0];
    endfunction

    function logic [55:0] specific_impulse(longint acc);
      logic signed [64:0] a65;
      logic [64:0]        mag;
      logic [127:0]       den;
      logic [127:0]       q;
      bit                 neg;
      if (acc == 0) return '0;
      neg = acc < 0;
      a65 = acc;
      mag = neg ? -a65 : a65;
      den = 128'(mass) * 128'(GRAVITY_SCALE);
      if (den == 0) begin
        q = neg ? ISP_NEG_LIMIT : ISP_POS_LIMIT;
      end else begin
        // Eight extra fraction bits, quotient truncated.
        q = {mag, 8'd0} / den;
        if (neg && q > ISP_NEG_LIMIT) q = ISP_NEG_LIMIT;
        if (!neg && q > ISP_POS_LIMIT) q = ISP_POS_LIMIT;
      end
      return neg ? -q[55:0] : q[55:0];
    endfunction

    function void note_sample(tcs_pkg::sample_t s);
      logic signed [23:0]  x;
      logic signed [24:0]  pair;
      logic signed [40:0]  dt;
      logic signed [127:0] wide;
      longint              mean;
      tcs_pkg::result_t    r;
      x = s.thrust_sample;
      if (have_prev) begin
        pair = {x[23], x} + {prev_thrust[23], prev_thrust};
        if (fixed_rate) dt = {11'd0, period};
        else dt = {1'b0, s.sample_time_ns} - {1'b0, prev_time};
        wide = pair * dt;
        wide = impulse_acc + sat64(wide);
        impulse_acc = sat64(wide);
      end
      have_prev   = 1'b1;
      prev_thrust = x;
      prev_time   = s.sample_time_ns;
      // Sum and count stop moving once the count is full.
      if (count < tcs_pkg::MAX_SAMPLES) begin
        thrust_sum = thrust_sum + x;
        if (thrust_sum > SUM_HI) thrust_sum = SUM_HI;
        if (thrust_sum < SUM_LO) thrust_sum = SUM_LO;
        count++;
      end
      if (x > $signed({1'b0, peak})) peak = x[22:0];
      if (!s.last_sample) return;

      mean = thrust_sum / count;
      if (mean > 64'sd8388607) mean = 64'sd8388607;
      if (mean < -64'sd8388608) mean = -64'sd8388608;
      r.total_impulse       = impulse_acc;
      r.specific_impulse_q8 = specific_impulse(impulse_acc);
      r.mean_thrust         = mean[23:0];
      r.peak_thrust         = peak;
      r.peak_ratio          = (rdiv == 0) ? tcs_pkg::PEAK_MAX : peak / rdiv;
      pending_runs.insert(pending_runs.size(), r);
      clear_run();
    endfunction

    function void field_check(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(tcs_pkg::result_t got);
      tcs_pkg::result_t want;
      if (pending_runs.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no run pending, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_runs.pop_front();
      field_check("total_impulse", want.total_impulse, got.total_impulse);
      field_check("specific_impulse_q8", want.specific_impulse_q8,
                  got.specific_impulse_q8);
      field_check("mean_thrust", want.mean_thrust, got.mean_thrust);
      field_check("peak_thrust", want.peak_thrust, got.peak_thrust);
      field_check("peak_ratio", want.peak_ratio, got.peak_ratio);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  tcs_pkg::cfg_index_t       cfg_index;
  logic [tcs_pkg::CFG_W-1:0] cfg_data;
  logic                      sample_valid;
  logic                      sample_ready;
  tcs_pkg::sample_t          sample;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  tcs_pkg::result_t          result;

  int            send_idle_pct  = 0;
  int            take_stall_pct = 0;
  int            cycles         = 0;
  int            random_sent    = 0;
  run_scoreboard sb;

  thrust_curve_statistics u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= take_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && sample_valid && sample_ready) sb.note_sample(sample);
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  task automatic put_sample(logic signed [23:0] th, logic [39:0] ts, bit last);
    tcs_pkg::sample_t s;
    s.thrust_sample  = th;
    s.sample_time_ns = ts;
    s.last_sample    = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  // Hold the sender until every run has reported, then let the back end settle.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_runs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(tcs_pkg::cfg_index_t idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic apply_setup(bit fixed, logic [29:0] per, logic [31:0] m,
                             logic [15:0] rd);
    cfg_write <= 1'b1;
    put_reg(tcs_pkg::CFG_USE_FIXED_RATE, {31'd0, fixed});
    put_reg(tcs_pkg::CFG_SAMPLE_PERIOD, {2'd0, per});
    put_reg(tcs_pkg::CFG_PROP_MASS, m);
    put_reg(tcs_pkg::CFG_RATIO_DIVISOR, {16'd0, rd});
    cfg_write <= 1'b0;
  endtask

  function automatic logic [39:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[39:0];
  endfunction

  function automatic logic signed [23:0] pick_thrust();
    case ($urandom_range(0, 9))
      0: return THRUST_MAX;
      1: return THRUST_MIN;
      2, 3: return 24'($urandom);
      default: return 24'($urandom_range(0, 60000)) - 24'd5000;
    endcase
  endfunction

  task automatic random_setup();
    logic [29:0] per;
    logic [31:0] m;
    logic [15:0] rd;
    case ($urandom_range(0, 4))
      0: per = '0;
      1: per = 30'd1;
      2: per = '1;
      3: per = 30'($urandom);
      default: per = 30'($urandom_range(100, 100000));
    endcase
    case ($urandom_range(0, 4))
      0: m = '0;
      1: m = 32'd1;
      2: m = '1;
      3: m = $urandom;
      default: m = $urandom_range(1000, 5000000);
    endcase
    case ($urandom_range(0, 4))
      0: rd = '0;
      1: rd = 16'd1;
      2: rd = '1;
      default: rd = 16'($urandom_range(2, 1000));
    endcase
    apply_setup(1'($urandom_range(0, 1)), per, m, rd);
  endtask

  // Mostly forward-moving timestamps, with the odd jump or step back.
  task automatic random_run();
    int          len;
    logic [39:0] ts;
    case ($urandom_range(0, 9))
      0: len = 1;
      1: len = $urandom_range(20, 40);
      default: len = $urandom_range(2, 10);
    endcase
    ts = ($urandom_range(0, 3) == 0) ? rand_time() : 40'($urandom);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 19))
        0: ts = rand_time();
        1: ts = ts - $urandom_range(1, 5000);
        default: ts = ts + $urandom_range(1, 2000000);
      endcase
      put_sample(pick_thrust(), ts, i == len - 1);
      random_sent++;
    end
  endtask

  initial begin
    int target;
    sb           = new();
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = tcs_pkg::CFG_USE_FIXED_RATE;
    cfg_data     = '0;
    sample_valid = 1'b0;
    sample       = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: fixed 1000 ns period. Single-sample runs at both extremes.
    put_sample(THRUST_MAX, 40'd0, 1'b1);
    put_sample(THRUST_MIN, 40'd0, 1'b1);
    put_sample(24'sd0, 40'd0, 1'b0);
    put_sample(24'sd256, 40'd0, 1'b0);
    put_sample(-24'sd256, 40'd0, 1'b0);
    put_sample(24'sd1000, 40'd0, 1'b1);
    wait_drained();

    // Timestamp mode with zero mass and zero divisor.
    apply_setup(1'b0, 30'd1000, 32'd0, 16'd0);
    // Positive term overflow, then a saturating add at the top.
    put_sample(THRUST_MIN, TIME_MAX, 1'b0);
    put_sample(THRUST_MIN, 40'd0, 1'b0);
    put_sample(THRUST_MAX, 40'd0, 1'b0);
    put_sample(THRUST_MAX, TIME_MAX, 1'b1);
    // The same at the negative limit.
    put_sample(THRUST_MAX, TIME_MAX, 1'b0);
    put_sample(THRUST_MAX, 40'd0, 1'b0);
    put_sample(THRUST_MIN, 40'd0, 1'b0);
    put_sample(THRUST_MIN, TIME_MAX, 1'b1);
    put_sample(24'sd500, 40'd100, 1'b1);
    put_sample(24'sd1000, 40'd5000, 1'b0);
    put_sample(24'sd2000, 40'd3000, 1'b1);
    wait_drained();

    // Zero sample period: every term vanishes.
    apply_setup(1'b1, 30'd0, 32'hFFFF_FFFF, 16'hFFFF);
    put_sample(24'sd100, 40'd0, 1'b0);
    put_sample(24'sd200, 40'd0, 1'b1);
    wait_drained();

    apply_setup(1'b1, {30{1'b1}}, 32'd1, 16'd3);
    put_sample(THRUST_MAX, 40'd0, 1'b0);
    put_sample(THRUST_MAX, 40'd0, 1'b0);
    put_sample(-24'sd7, 40'd0, 1'b1);

    for (int pass = 0; pass < 2; pass++) begin
      for (int ph = 0; ph < 4; ph++) begin
        wait_drained();
        case (ph)
          0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
          1: begin send_idle_pct = 70; take_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  take_stall_pct = 70; end
          default: begin send_idle_pct = 25; take_stall_pct = 25; end
        endcase
        random_setup();
        target = random_sent + RANDOM_ITEMS / 8;
        while (random_sent < target) random_run();
      end
    end

    wait_drained();
    if (sb.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
